// ===== hdl/bmm_pkg.sv =====
package bmm_pkg;

  // Screen geometry of the LCD port
  localparam int unsigned SCREEN_WIDTH  = 98;
  localparam int unsigned SCREEN_HEIGHT = 67;

  // Field widths
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BANK_W    = 16;
  localparam int unsigned MEM_ADDR_W = 21;
  localparam int unsigned COORD_W   = 7;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Packed channel widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 64;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BIOS_BANK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_BANK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BANK    = 2'd2;

  // Bank register reset values
  localparam logic [BANK_W-1:0] BIOS_BANK_RST    = 16'he000;
  localparam logic [BANK_W-1:0] PROGRAM_BANK_RST = 16'h7202;
  localparam logic [BANK_W-1:0] DATA_BANK_RST    = 16'h78c0;

  // Bank decode masks and matches
  localparam logic [BANK_W-1:0] OTP_MASK    = 16'h9e00;
  localparam logic [BANK_W-1:0] OTP_HI      = 16'h1e00;
  localparam logic [BANK_W-1:0] VIDEO_MASK  = 16'h9f00;
  localparam logic [BANK_W-1:0] VIDEO_MATCH = 16'h0300;
  localparam logic [BANK_W-1:0] FLASH_MASK  = 16'h9c00;
  localparam logic [BANK_W-1:0] FLASH_MATCH = 16'h0400;

  // Video port read values
  localparam logic [BYTE_W-1:0] VIDEO_CTRL_RD = 8'hca;
  localparam logic [BYTE_W-1:0] VIDEO_DATA_RD = 8'hff;

  // Access kind
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [2:0] {
    TGT_NONE  = 3'd0,
    TGT_RAM   = 3'd1,
    TGT_OTP   = 3'd2,
    TGT_FLASH = 3'd3,
    TGT_VIDEO = 3'd4
  } target_t;

  // One result item
  typedef struct packed {
    target_t               target;
    logic [MEM_ADDR_W-1:0] mem_address;
    logic                  mem_write;
    logic [BYTE_W-1:0]     video_read_data;
    logic                  pixel_valid;
    logic [COORD_W-1:0]    pixel_x;
    logic [COORD_W-1:0]    pixel_y;
    logic [COLOR_W-1:0]    pixel_color;
  } result_t;

endpackage

// ===== hdl/banked_memory_mapper_with_lcd_port.sv =====
// Banked memory mapper with an LCD port. Each input item is one CPU bus
// access (kind in in_tuser, address and data byte in in_tdata); each
// produces exactly one result item naming the target memory (in out_tuser),
// the physical address, the RAM write strobe, the fixed video read byte and,
// for the second byte of a video data write, a completed 16-bit pixel with
// its screen position. The block takes one item every cycle while out_tready
// holds; each item passes through the input register, then the result register.
// The user must write the bank registers through the cfg_ port only while no
// access is in flight; the block itself does not enforce it. Index 3 is ignored.
module banked_memory_mapper_with_lcd_port (
  input  logic                               clk,
  input  logic                               rst_n,
  // config write port
  input  logic                               cfg_we,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmm_pkg::BANK_W-1:0]         cfg_wdata,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bmm_pkg::IN_DATA_W-1:0]      in_tdata,   // address[15:0], write_data[23:16]
  input  logic                               in_tuser,   // func
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // mem_address[20:0], mem_write[21], video_read_data[29:22], pixel_valid[30],
  // pixel_x[37:31], pixel_y[44:38], pixel_color[60:45], zero[63:61]
  output logic [bmm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [2:0]                         out_tuser   // target
);
  import bmm_pkg::*;

  // bank registers
  logic [BANK_W-1:0] bios_bank_r, program_bank_r, data_bank_r;

  // input stage
  logic              s1_valid_r;
  logic              s1_func_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [BYTE_W-1:0] s1_data_r;

  // LCD cursor state
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic               phase_r, phase_nxt;
  logic [BYTE_W-1:0]  high_byte_r, high_byte_nxt;

  // result stage
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic s1_adv;
  logic out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // write bank registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bios_bank_r    <= BIOS_BANK_RST;
      program_bank_r <= PROGRAM_BANK_RST;
      data_bank_r    <= DATA_BANK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIOS_BANK:    bios_bank_r    <= cfg_wdata;
        REG_PROGRAM_BANK: program_bank_r <= cfg_wdata;
        REG_DATA_BANK:    data_bank_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // decode the registered access
  logic [BANK_W-1:0]     bank;
  logic [ADDR_W-1:0]     offset;
  logic                  is_ram;
  logic                  fixed_ram;
  logic [13:0]           otp_addr;
  logic [MEM_ADDR_W-1:0] flash_addr;
  logic                  is_wr;
  logic                  pix_step;
  logic [COORD_W-1:0]    col_inc;
  logic [COORD_W-1:0]    row_tmp;

  assign is_wr     = (s1_func_r == FUNC_WRITE);
  assign fixed_ram = (s1_addr_r >= 16'h0080) && (s1_addr_r <= 16'h1fff);

  always_comb begin
    bank   = '0;
    offset = '0;
    is_ram = 1'b0;
    if (s1_addr_r[15]) begin
      bank   = {1'b0, data_bank_r[12:0], 2'b00};
      is_ram = data_bank_r[15];
      offset = {1'b0, s1_addr_r[14:0]};
    end else if (s1_addr_r[14]) begin
      bank   = {1'b0, program_bank_r[13:0], 1'b0};
      is_ram = program_bank_r[15];
      offset = {2'b00, s1_addr_r[13:0]};
    end else if (s1_addr_r[13]) begin
      bank   = bios_bank_r;
      is_ram = bios_bank_r[15];
      offset = {3'b000, s1_addr_r[12:0]};
    end
  end

  assign otp_addr   = {bank[0], 13'd0} + offset[13:0];
  assign flash_addr = {bank[7:0], 13'd0} + {6'd0, offset[14:0]};

  // build the result and the next cursor state
  always_comb begin
    res_nxt       = '0;
    pix_step      = 1'b0;
    phase_nxt     = phase_r;
    high_byte_nxt = high_byte_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    col_inc       = col_r + 7'd1;
    row_tmp       = row_r;

    if (fixed_ram) begin
      res_nxt.target      = TGT_RAM;
      res_nxt.mem_address = {5'd0, s1_addr_r};
      res_nxt.mem_write   = is_wr;
    end else if (is_ram) begin
      res_nxt.target      = TGT_RAM;
      res_nxt.mem_address = {6'd0, s1_addr_r[14:0]};
      res_nxt.mem_write   = is_wr;
    end else if ((bank & OTP_MASK) == '0 || (bank & OTP_MASK) == OTP_HI) begin
      res_nxt.target      = TGT_OTP;
      res_nxt.mem_address = {7'd0, otp_addr};
    end else if ((bank & VIDEO_MASK) == VIDEO_MATCH) begin
      res_nxt.target = TGT_VIDEO;
      if (!is_wr) begin
        res_nxt.video_read_data = s1_addr_r[0] ? VIDEO_DATA_RD : VIDEO_CTRL_RD;
      end else if (s1_addr_r[0]) begin
        pix_step = 1'b1;
      end
    end else if ((bank & FLASH_MASK) == FLASH_MATCH) begin
      res_nxt.target      = TGT_FLASH;
      res_nxt.mem_address = flash_addr;
    end

    // pair bytes into a pixel and advance the cursor
    if (pix_step) begin
      if (!phase_r) begin
        high_byte_nxt = s1_data_r;
        phase_nxt     = 1'b1;
      end else begin
        res_nxt.pixel_valid = 1'b1;
        res_nxt.pixel_x     = col_r;
        res_nxt.pixel_y     = row_r;
        res_nxt.pixel_color = {high_byte_r, s1_data_r};
        col_nxt = col_inc;
        if (col_inc >= COORD_W'(SCREEN_WIDTH)) begin
          col_nxt = '0;
          row_tmp = row_r + 7'd1;
        end
        row_nxt   = (row_tmp >= COORD_W'(SCREEN_HEIGHT)) ? '0 : row_tmp;
        phase_nxt = 1'b0;
      end
    end
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= 1'b0;
      high_byte_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        phase_r     <= phase_nxt;
        high_byte_r <= high_byte_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture the item and the result
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_func_r <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.target;
  assign out_tdata  = {3'b000, res_r.pixel_color, res_r.pixel_y, res_r.pixel_x,
                       res_r.pixel_valid, res_r.video_read_data, res_r.mem_write,
                       res_r.mem_address};

endmodule

// ===== tb/banked_memory_mapper_with_lcd_port_tb.sv =====
module banked_memory_mapper_with_lcd_port_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int FRAME_WRITES = 2 * SCREEN_WIDTH * 3 + 40;

  // Tracks the mapper state and checks every result item in order
  class access_scoreboard;
    logic [BANK_W-1:0]  bios_bank;
    logic [BANK_W-1:0]  program_bank;
    logic [BANK_W-1:0]  data_bank;
    logic [COORD_W-1:0] cursor_col;
    logic [COORD_W-1:0] cursor_row;
    bit                 second_byte;
    logic [BYTE_W-1:0]  high_byte;
    result_t            expected_results[$];
    int unsigned        errors;
    int unsigned        target_hits[5];
    int unsigned        pixels;

    function new();
      bios_bank    = BIOS_BANK_RST;
      program_bank = PROGRAM_BANK_RST;
      data_bank    = DATA_BANK_RST;
      cursor_col   = '0;
      cursor_row   = '0;
      second_byte  = 1'b0;
      high_byte    = '0;
      errors       = 0;
      pixels       = 0;
      foreach (target_hits[i]) target_hits[i] = 0;
    endfunction

    function void set_banks(logic [BANK_W-1:0] b, logic [BANK_W-1:0] p,
                            logic [BANK_W-1:0] d);
      bios_bank    = b;
      program_bank = p;
      data_bank    = d;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Decode one bus access and advance the LCD cursor state
    function result_t decode_access(logic wr, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d);
      result_t     r;
      logic [15:0] bank;
      logic [14:0] ofs;
      bit          ram_sel;
      int unsigned phys;
      r       = '0;
      bank    = '0;
      ofs     = '0;
      ram_sel = 1'b0;
      if (a >= 16'h0080 && a <= 16'h1fff) begin
        r.target      = TGT_RAM;
        r.mem_address = MEM_ADDR_W'(a);
        r.mem_write   = wr;
        return r;
      end
      // pick the window; the low page falls through as bank 0, offset 0
      if (a[15]) begin
        bank    = {1'b0, data_bank[12:0], 2'b00};
        ram_sel = data_bank[15];
        ofs     = a[14:0];
      end else if (a[14]) begin
        bank    = {1'b0, program_bank[13:0], 1'b0};
        ram_sel = program_bank[15];
        ofs     = {1'b0, a[13:0]};
      end else if (a[13]) begin
        bank    = bios_bank;
        ram_sel = bios_bank[15];
        ofs     = {2'b00, a[12:0]};
      end
      if (ram_sel) begin
        r.target      = TGT_RAM;
        r.mem_address = MEM_ADDR_W'(a[14:0]);
        r.mem_write   = wr;
      end else if ((bank & OTP_MASK) == 16'h0000 || (bank & OTP_MASK) == OTP_HI) begin
        r.target      = TGT_OTP;
        phys          = (int'(bank[0]) * 32'h2000 + int'(ofs)) & 32'h3fff;
        r.mem_address = MEM_ADDR_W'(phys);
      end else if ((bank & VIDEO_MASK) == VIDEO_MATCH) begin
        r.target = TGT_VIDEO;
        if (wr == FUNC_READ) begin
          r.video_read_data = a[0] ? VIDEO_DATA_RD : VIDEO_CTRL_RD;
        end else if (a[0]) begin
          // pair bytes into a pixel, high byte first
          if (!second_byte) begin
            high_byte   = d;
            second_byte = 1'b1;
          end else begin
            r.pixel_valid = 1'b1;
            r.pixel_x     = cursor_col;
            r.pixel_y     = cursor_row;
            r.pixel_color = {high_byte, d};
            cursor_col    = cursor_col + 1'b1;
            if (cursor_col >= SCREEN_WIDTH) begin
              cursor_col = '0;
              cursor_row = cursor_row + 1'b1;
            end
            if (cursor_row >= SCREEN_HEIGHT) cursor_row = '0;
            second_byte = 1'b0;
          end
        end
      end else if ((bank & FLASH_MASK) == FLASH_MATCH) begin
        r.target      = TGT_FLASH;
        phys          = (int'(bank[7:0]) * 32'h2000 + int'(ofs)) & 32'h1fffff;
        r.mem_address = MEM_ADDR_W'(phys);
      end else begin
        r.target = TGT_NONE;
      end
      return r;
    endfunction

    function void note_access(logic wr, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d);
      result_t r;
      r = decode_access(wr, a, d);
      target_hits[r.target]++;
      if (r.pixel_valid) pixels++;
      expected_results.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, e, a);
      end
    endfunction

    function void check_result(logic [2:0] tgt, logic [OUT_DATA_W-1:0] td);
      result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result item with none expected, expected none, actual 0x%0h/0x%0h",
                   $time, tgt, td);
        return;
      end
      e = expected_results.pop_front();
      compare("target", 32'(e.target), 32'(tgt));
      compare("mem_address", 32'(e.mem_address), 32'(td[20:0]));
      compare("mem_write", 32'(e.mem_write), 32'(td[21]));
      compare("video_read_data", 32'(e.video_read_data), 32'(td[29:22]));
      compare("pixel_valid", 32'(e.pixel_valid), 32'(td[30]));
      compare("pixel_x", 32'(e.pixel_x), 32'(td[37:31]));
      compare("pixel_y", 32'(e.pixel_y), 32'(td[44:38]));
      compare("pixel_color", 32'(e.pixel_color), 32'(td[60:45]));
      compare("tdata padding", 32'd0, 32'(td[63:61]));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BIOS_BANK;
  logic [BANK_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // address[15:0], write_data[23:16]
  logic                  in_tuser = 1'b0;  // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // mem_address[20:0], mem_write[21], video_read_data[29:22], pixel_valid[30],
  // pixel_x[37:31], pixel_y[44:38], pixel_color[60:45], zero[63:61]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;        // target

  access_scoreboard board = new();
  bit               no_gaps = 1'b0;
  int               idle_cycles = 0;

  banked_memory_mapper_with_lcd_port uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random outside the steady stretch
  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 21);
  end

  // Check each accepted result item
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tuser, out_tdata);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles with no item moving", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one bus access, with random idle cycles ahead of it
  task automatic send_access(input logic wr, input logic [ADDR_W-1:0] a,
                             input logic [BYTE_W-1:0] d);
    while (!no_gaps && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, a};
    in_tuser  <= wr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_access(wr, a, d);
  endtask

  // Stop offering items and wait for every result to come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_banks(input logic [BANK_W-1:0] b, input logic [BANK_W-1:0] p,
                             input logic [BANK_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BIOS_BANK;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_index <= REG_PROGRAM_BANK;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_index <= REG_DATA_BANK;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_banks(b, p, d);
  endtask

  // Pick a register value for window win that lands on a random target kind
  function automatic logic [BANK_W-1:0] pick_bank(input int win, output bit video);
    logic [15:0] v;
    int          kind;
    kind  = $urandom_range(6);
    video = 1'b0;
    v     = 16'($urandom);
    v[15] = 1'b0;
    case (kind)
      0: return 16'($urandom) | 16'h8000;
      1: v[12:9] = $urandom_range(1) ? 4'hf : 4'h0;
      2: begin
        v[12:8] = 5'b00011;
        video   = 1'b1;
      end
      3: v[12:10] = 3'b001;
      4: begin
        while ((v & OTP_MASK) == 16'h0000 || (v & OTP_MASK) == OTP_HI ||
               (v & VIDEO_MASK) == VIDEO_MATCH || (v & FLASH_MASK) == FLASH_MATCH) begin
          v     = 16'($urandom);
          v[15] = 1'b0;
        end
      end
      5: return 16'($urandom);
      default: return $urandom_range(1) ? 16'hffff : 16'h0000;
    endcase
    // undo the window's shift, spare top bits random
    if (win == 1) return {1'b0, 1'($urandom), v[14:1]};
    if (win == 2) return {1'b0, 2'($urandom), v[14:2]};
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] video_address(input int win);
    logic [ADDR_W-1:0] a;
    case (win)
      0:       a = {3'b001, 13'($urandom)};
      1:       a = {2'b01, 14'($urandom)};
      default: a = {1'b1, 15'($urandom)};
    endcase
    a[0] = 1'b1;
    return a;
  endfunction

  initial begin
    logic [BANK_W-1:0] b, p, d;
    bit [2:0]          vid;
    bit                flag;
    logic [ADDR_W-1:0] a;
    logic              wr;
    int                k;
    int                w;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset banks: bios RAM, program flash, data video
    send_access(FUNC_READ, 16'h0000, 8'h00);
    send_access(FUNC_WRITE, 16'h007f, 8'hff);
    send_access(FUNC_WRITE, 16'h0080, 8'hff);
    send_access(FUNC_READ, 16'h1fff, 8'h00);
    send_access(FUNC_WRITE, 16'h2000, 8'h5a);
    send_access(FUNC_WRITE, 16'h7fff, 8'ha5);
    send_access(FUNC_READ, 16'h8000, 8'h00);
    send_access(FUNC_READ, 16'hffff, 8'h00);
    send_access(FUNC_WRITE, 16'h8000, 8'h77);
    send_access(FUNC_WRITE, 16'h8001, 8'hff);
    send_access(FUNC_WRITE, 16'hffff, 8'h00);
    drain();

    // OTP odd bank, OTP high pattern, flash at the top of its range
    write_banks(16'h0001, 16'h0f00, 16'h01ff);
    send_access(FUNC_READ, 16'h2000, 8'h00);
    send_access(FUNC_WRITE, 16'h3fff, 8'h11);
    send_access(FUNC_READ, 16'h4000, 8'h00);
    send_access(FUNC_WRITE, 16'hffff, 8'h22);
    drain();

    // Unmapped bank, all-ones and all-zeros registers
    write_banks(16'h0800, 16'hffff, 16'h0000);
    send_access(FUNC_READ, 16'h2abc, 8'h00);
    send_access(FUNC_WRITE, 16'h5555, 8'h33);
    send_access(FUNC_WRITE, 16'hc123, 8'h44);
    drain();

    // Video through the bios window, then the other extremes
    write_banks(16'h0300, 16'h0000, 16'hffff);
    send_access(FUNC_WRITE, 16'h2001, 8'hf0);
    send_access(FUNC_WRITE, 16'h2001, 8'h0f);
    send_access(FUNC_READ, 16'h2002, 8'h00);
    send_access(FUNC_READ, 16'h4001, 8'h00);
    send_access(FUNC_WRITE, 16'hfffe, 8'h99);
    drain();

    // Random phases, 45 percent video accesses (mostly pixel writes) where a video window exists
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      b = pick_bank(0, flag);
      vid[0] = flag;
      p = pick_bank(1, flag);
      vid[1] = flag;
      d = pick_bank(2, flag);
      vid[2] = flag;
      write_banks(b, p, d);
      no_gaps = (ph == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        k  = $urandom_range(99);
        wr = 1'($urandom_range(1));
        if (k < 5) begin
          a = 16'($urandom_range(16'h007f));
        end else if (k < 20) begin
          a = 16'($urandom_range(16'h1fff, 16'h0080));
        end else if (k < 65 && vid != 3'b000) begin
          w = $urandom_range(2);
          while (!vid[w]) w = $urandom_range(2);
          a  = video_address(w);
          wr = ($urandom_range(9) != 0) ? FUNC_WRITE : FUNC_READ;
        end else begin
          a = 16'($urandom);
        end
        send_access(wr, a, 8'($urandom));
      end
      drain();
    end

    // Draw several full rows so the column wraps and the row advances
    write_banks(16'h0300, pick_bank(1, flag), pick_bank(2, flag));
    for (int n = 0; n < FRAME_WRITES; n++) begin
      no_gaps = (n < FRAME_WRITES / 2);
      send_access(FUNC_WRITE, video_address(0), 8'($urandom));
    end
    no_gaps = 1'b0;
    drain();

    $display("Covered targets none/RAM/OTP/flash/video: %0d/%0d/%0d/%0d/%0d",
             board.target_hits[TGT_NONE], board.target_hits[TGT_RAM],
             board.target_hits[TGT_OTP], board.target_hits[TGT_FLASH],
             board.target_hits[TGT_VIDEO]);
    $display("Pixels drawn: %0d over %0d bank settings, %0d mismatches",
             board.pixels, RANDOM_PHASES + 5, board.errors);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bmm_pkg.sv
hdl/banked_memory_mapper_with_lcd_port.sv
tb/banked_memory_mapper_with_lcd_port_tb.sv
